FILE: rtl/i2cmts_pkg.sv
// Package for the I2C master transfer sequencer.
// Holds the item kind, phase, status and completion codes and the command and result types.
// No dependencies.
package i2cmts_pkg;

  localparam logic [1:0] MODE_START_WR = 2'd0;
  localparam logic [1:0] MODE_START_RD = 2'd1;
  localparam logic [1:0] MODE_EVENT    = 2'd2;
  localparam logic [1:0] MODE_NONE     = 2'd3;

  localparam logic [1:0] PHASE_READY = 2'd0;
  localparam logic [1:0] PHASE_TX    = 2'd1;
  localparam logic [1:0] PHASE_RX    = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_BUSY = 2'd2;

  localparam logic [1:0] CMPL_NONE = 2'd0;
  localparam logic [1:0] CMPL_TX   = 2'd1;
  localparam logic [1:0] CMPL_RX   = 2'd2;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 32;

  typedef struct packed {
    logic [1:0] kind;
    logic       zero_len;
    logic [6:0] slave_address;
    logic       repeated_start;
    logic       sb;
    logic       adf;
    logic       btf;
    logic       txe;
    logic       rxne;
    logic [7:0] rx_data;
    logic [7:0] tx_data;
  } cmd_t;

  typedef struct packed {
    logic [1:0] completion;
    logic [7:0] rx_value;
    logic       rx_valid;
    logic       ack_level;
    logic       clear_address_flag;
    logic       tx_taken;
    logic [7:0] data_write_value;
    logic       data_write_valid;
    logic       stop_request;
    logic       start_request;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    logic events_enabled;
  } bk_stat_t;

endpackage

FILE: rtl/i2c_master_transfer_sequencer.sv
// I2C master transfer sequencer: front end, two-entry queue, back end with result register.
// Each item passes through the queue, and its result is held in the result register until out_tready takes it.
// Throughput: one item per cycle while the result register is empty or out_tready is high.
// Reset: rst_n is synchronous and active low; it empties the queue and the output register,
// sets the phase to ready, clears counters and sets ACK and the ACK default to 1.
module i2c_master_transfer_sequencer #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata, from bit 0: slave_address[6:0], transfer_length[15:0], repeated_start,
  // flag_start_sent, flag_address_done, flag_byte_finished, flag_tx_empty,
  // flag_rx_not_empty, rx_data[7:0], tx_data[7:0], zero fill.
  input  logic [47:0] in_tdata,
  // in_tuser, from bit 0: mode[1:0].
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata, from bit 0: status[1:0], start_request, stop_request, data_write_valid,
  // data_write_value[7:0], tx_taken, clear_address_flag, ack_level, rx_valid,
  // rx_value[7:0], completion[1:0], zero fill.
  output logic [31:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  localparam int unsigned QW = $bits(i2cmts_pkg::cmd_t) + LENGTH_BITS;

  i2cmts_pkg::cmd_t     f_cmd, q_cmd;
  logic [LENGTH_BITS-1:0] f_len, q_len;
  logic [QW-1:0]        q_out;
  logic                 push, pop;
  i2cmts_pkg::q_stat_t  q_stat;
  i2cmts_pkg::bk_stat_t bk_stat;

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;
  assign q_cmd     = q_out[QW-1:LENGTH_BITS];
  assign q_len     = q_out[LENGTH_BITS-1:0];

  i2cmts_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cmd      (f_cmd),
    .len      (f_len)
  );

  i2cmts_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_cmd, f_len}),
    .pop       (pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  i2cmts_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (!q_stat.empty),
    .q_cmd       (q_cmd),
    .q_len       (q_len),
    .q_pop       (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .stat        (bk_stat)
  );

`ifndef ASSERT_OFF
  a_events_match_phase: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.events_enabled == bk_stat.busy)
    else $error("events enabled outside an active transfer");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_queue_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  a_push_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.full && !out_tvalid) |=> !q_stat.full)
    else $error("queue stays full with the output free");
`endif

endmodule

FILE: rtl/i2cmts_front.sv
// Front end of the I2C master transfer sequencer: unpacks and classifies input items.
// Depends on i2cmts_pkg.
module i2cmts_front #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic [i2cmts_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [1:0]                       in_tuser,
  output i2cmts_pkg::cmd_t                 cmd,
  output logic [LENGTH_BITS-1:0]           len
);

  logic [15:0] raw_len;

  always_comb begin
    raw_len            = in_tdata[22:7];
    len                = LENGTH_BITS'({16'd0, raw_len});
    cmd.zero_len       = (len == '0);
    cmd.slave_address  = in_tdata[6:0];
    cmd.repeated_start = in_tdata[23];
    cmd.sb             = in_tdata[24];
    cmd.adf            = in_tdata[25];
    cmd.btf            = in_tdata[26];
    cmd.txe            = in_tdata[27];
    cmd.rxne           = in_tdata[28];
    cmd.rx_data        = in_tdata[36:29];
    cmd.tx_data        = in_tdata[44:37];
    unique case (in_tuser)
      i2cmts_pkg::MODE_START_WR: cmd.kind = i2cmts_pkg::MODE_START_WR;
      i2cmts_pkg::MODE_START_RD: cmd.kind = i2cmts_pkg::MODE_START_RD;
      i2cmts_pkg::MODE_EVENT:    cmd.kind = i2cmts_pkg::MODE_EVENT;
      default:                   cmd.kind = i2cmts_pkg::MODE_NONE;
    endcase
  end

endmodule

FILE: rtl/i2cmts_queue.sv
// Two-entry queue between the front end and the back end of the sequencer.
// Depends on i2cmts_pkg.
module i2cmts_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    pop_data,
  output i2cmts_pkg::q_stat_t stat
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  always_comb begin
    stat.full  = (count_r == 2'd2);
    stat.empty = (count_r == 2'd0);
    pop_data   = mem_r[rd_ptr_r];
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/i2cmts_back.sv
// Back end of the sequencer: holds the transfer state, executes commands, registers results.
// Depends on i2cmts_pkg.
module i2cmts_back #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data,
  input  logic                              q_valid,
  input  i2cmts_pkg::cmd_t                  q_cmd,
  input  logic [LENGTH_BITS-1:0]            q_len,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [i2cmts_pkg::OUT_DATA_W-1:0] out_tdata,
  output i2cmts_pkg::bk_stat_t              stat
);

  localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LEN_TWO = LENGTH_BITS'(2);

  logic                   ack_default_r;
  logic [1:0]             phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic [LENGTH_BITS-1:0] read_total_r, read_total_nxt;
  logic [6:0]             target_r, target_nxt;
  logic                   skip_stop_r, skip_stop_nxt;
  logic                   ack_bit_r, ack_bit_nxt;
  logic                   events_en_r, events_en_nxt;
  logic                   out_valid_r;
  i2cmts_pkg::res_t       res, res_r;
  logic                   busy;

  assign q_pop      = q_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(i2cmts_pkg::OUT_DATA_W - $bits(i2cmts_pkg::res_t)){1'b0}}, res_r};
  assign busy       = (phase_r == i2cmts_pkg::PHASE_TX) || (phase_r == i2cmts_pkg::PHASE_RX);
  assign stat.busy           = busy;
  assign stat.events_enabled = events_en_r;

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    read_total_nxt = read_total_r;
    target_nxt     = target_r;
    skip_stop_nxt  = skip_stop_r;
    ack_bit_nxt    = ack_bit_r;
    events_en_nxt  = events_en_r;
    res            = '0;
    unique case (q_cmd.kind) inside
      i2cmts_pkg::MODE_START_WR, i2cmts_pkg::MODE_START_RD: begin
        if (q_cmd.zero_len) begin
          res.status = i2cmts_pkg::STATUS_ZERO;
        end else if (busy) begin
          res.status = i2cmts_pkg::STATUS_BUSY;
        end else begin
          bytes_left_nxt = q_len;
          if (q_cmd.kind == i2cmts_pkg::MODE_START_RD) begin
            read_total_nxt = q_len;
            phase_nxt      = i2cmts_pkg::PHASE_RX;
          end else begin
            phase_nxt      = i2cmts_pkg::PHASE_TX;
          end
          target_nxt        = q_cmd.slave_address;
          skip_stop_nxt     = q_cmd.repeated_start;
          events_en_nxt     = 1'b1;
          res.start_request = 1'b1;
        end
      end
      i2cmts_pkg::MODE_EVENT: begin
        if (events_en_r) begin
          if (q_cmd.sb && phase_r == i2cmts_pkg::PHASE_TX) begin
            res.data_write_valid = 1'b1;
            res.data_write_value = {target_r, 1'b0};
          end else if (q_cmd.sb && phase_r == i2cmts_pkg::PHASE_RX) begin
            res.data_write_valid = 1'b1;
            res.data_write_value = {target_r, 1'b1};
          end
          if (q_cmd.adf) begin
            if (phase_r == i2cmts_pkg::PHASE_RX && read_total_r == LEN_ONE) begin
              ack_bit_nxt = 1'b0;
            end
            res.clear_address_flag = 1'b1;
          end
          if (q_cmd.btf && q_cmd.txe && phase_r == i2cmts_pkg::PHASE_TX &&
              bytes_left_r == '0) begin
            res.stop_request = !skip_stop_r;
            events_en_nxt    = 1'b0;
            bytes_left_nxt   = '0;
            phase_nxt        = i2cmts_pkg::PHASE_READY;
            res.completion   = i2cmts_pkg::CMPL_TX;
          end
          if (q_cmd.txe && phase_nxt == i2cmts_pkg::PHASE_TX && bytes_left_nxt != '0) begin
            res.data_write_valid = 1'b1;
            res.data_write_value = q_cmd.tx_data;
            res.tx_taken         = 1'b1;
            bytes_left_nxt       = bytes_left_nxt - LEN_ONE;
          end
          if (q_cmd.rxne && phase_nxt == i2cmts_pkg::PHASE_RX) begin
            if (read_total_r != '0) begin
              if (read_total_r != LEN_ONE && bytes_left_nxt == LEN_TWO) begin
                ack_bit_nxt = 1'b0;
              end
              res.rx_valid = 1'b1;
              res.rx_value = q_cmd.rx_data;
              if (bytes_left_nxt != '0) begin
                bytes_left_nxt = bytes_left_nxt - LEN_ONE;
              end
            end
            if (bytes_left_nxt == '0) begin
              res.stop_request = !skip_stop_r;
              events_en_nxt    = 1'b0;
              phase_nxt        = i2cmts_pkg::PHASE_READY;
              if (ack_default_r) begin
                ack_bit_nxt = 1'b1;
              end
              res.completion = i2cmts_pkg::CMPL_RX;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.ack_level = ack_bit_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_default_r <= 1'b1;
      phase_r       <= i2cmts_pkg::PHASE_READY;
      bytes_left_r  <= '0;
      read_total_r  <= '0;
      target_r      <= 7'd0;
      skip_stop_r   <= 1'b0;
      ack_bit_r     <= 1'b1;
      events_en_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ack_default_r <= cfg_wr_data;
      end
      if (q_pop) begin
        phase_r      <= phase_nxt;
        bytes_left_r <= bytes_left_nxt;
        read_total_r <= read_total_nxt;
        target_r     <= target_nxt;
        skip_stop_r  <= skip_stop_nxt;
        ack_bit_r    <= ack_bit_nxt;
        events_en_r  <= events_en_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

endmodule
